// ----- sv/bei_pkg.sv -----
// Shared types, constants and codes for the breakpoint envelope interpolator.
`timescale 1ns / 1ps

package bei_pkg;

	localparam int MAX_POINTS = 256;
	localparam int PTR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int TIME_W     = 31;
	localparam int LEVEL_W    = 8;
	localparam int OUT_W      = 16;
	localparam int FRAC_W     = 16;
	localparam int FCNT_W     = $clog2(FRAC_W + 1);
	localparam int PROD_W     = LEVEL_W + FRAC_W + 2;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_EVAL   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_CLAMP = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [TIME_W-1:0]  delta_time;
		logic [LEVEL_W-1:0] point_level;
		logic [TIME_W-1:0]  sample_time;
	} cmd_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] level_out;
		logic [1:0]       status;
	} res_word_t;

	typedef struct packed {
		logic [TIME_W-1:0]  ptime;
		logic [LEVEL_W-1:0] plevel;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] num;
		logic [TIME_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- sv/bei_table.sv -----
// Breakpoint table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bei_table (
	input  logic                     clk,
	input  bei_pkg::tbl_wr_t         wr,
	input  logic [bei_pkg::PTR_W-1:0] rd_addr,
	output bei_pkg::entry_t          rd_data
);
	import bei_pkg::*;

	entry_t mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- sv/bei_div.sv -----
// Restoring divider giving a 16-bit fraction, one quotient bit per cycle.
`timescale 1ns / 1ps

module bei_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bei_pkg::div_req_t req,
	output bei_pkg::div_rsp_t rsp
);
	import bei_pkg::*;

	logic [TIME_W:0]   rem_q;
	logic [TIME_W-1:0] den_q;
	logic [FRAC_W-1:0] quot_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [TIME_W:0]   rem_sh;
	logic              fits;

	// The numerator is always below the divisor, so the remainder stays
	// within 31 bits and its doubled form within 32.
	assign rem_sh = {rem_q[TIME_W-1:0], 1'b0};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !req.start && (cnt_q == FCNT_W'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= FCNT_W'(FRAC_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == FCNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {1'b0, req.num};
			den_q  <= req.den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quot_q <= {quot_q[FRAC_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ----- sv/breakpoint_envelope_interpolator.sv -----
// Top level of the breakpoint envelope interpolator: sequencer, table and divider.
`timescale 1ns / 1ps

// The block takes command words on the cmd channel and returns exactly one
// result word on the res channel for each of them. Both channels use valid
// and stall; a word moves at a clock edge where valid is high and stall low.
// A clear word empties the breakpoint table and rewinds the cursor; an append
// word adds a breakpoint whose time is the last time plus the delta, held at
// the largest 31-bit value; an evaluate word gives the envelope level at a
// sample time in unsigned 8.8 form, interpolated between two breakpoints.
// The block works on one word at a time and holds cmd_stall high until the
// result of that word has been placed in the output register. An evaluate
// that interpolates reads the table once for each breakpoint the cursor
// skips, once for the point after the sample and once for the point before
// it. The interpolation then runs the restoring divider for its 16 quotient
// bits and goes on through a multiply state and a sum state. Held levels,
// clamped samples and zero spans skip the divider. The output register lets
// the next word be accepted while a result waits under res_stall; that next
// result then waits in its own stage. Reset empties the table and clears
// res_valid; old table contents are never read.
module breakpoint_envelope_interpolator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  bei_pkg::cmd_word_t cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output bei_pkg::res_word_t res
);
	import bei_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_WALK, S_PREV, S_LAST, S_DIV, S_MUL, S_FIN, S_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   cursor_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [TIME_W-1:0]  sample_q;
	logic [TIME_W-1:0]  t1_q;
	logic [LEVEL_W-1:0] v0_q;
	logic [LEVEL_W-1:0] v1_q;
	logic [FRAC_W-1:0]  frac_q;
	logic signed [PROD_W-1:0] prod_q;
	res_word_t          pend_q;
	res_word_t          res_q;
	logic               res_valid_q;

	tbl_wr_t            tbl_wr;
	logic [PTR_W-1:0]   rd_addr;
	entry_t             rd_data;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               accept;
	logic [TIME_W:0]    sum_time;
	logic [TIME_W-1:0]  new_time;
	logic [CNT_W-1:0]   next_cursor;
	logic               full;
	logic signed [LEVEL_W:0] diff;
	logic signed [PROD_W-1:0] lvl;

	assign accept      = cmd_valid && !cmd_stall;
	assign cmd_stall   = (state_q != S_IDLE);
	assign full        = (count_q == CNT_W'(MAX_POINTS));
	assign next_cursor = cursor_q + 1'b1;

	// Appended times saturate rather than wrap.
	assign sum_time = {1'b0, last_time_q} + {1'b0, cmd.delta_time};
	assign new_time = sum_time[TIME_W] ? {TIME_W{1'b1}} : sum_time[TIME_W-1:0];

	assign tbl_wr.en         = accept && (cmd.operation == OP_APPEND) && !full;
	assign tbl_wr.addr       = count_q[PTR_W-1:0];
	assign tbl_wr.data.ptime  = new_time;
	assign tbl_wr.data.plevel = cmd.point_level;

	// The read address is steered ahead of each state so that the entry
	// arrives exactly when the following state looks at it.
	always_comb begin
		rd_addr = cursor_q[PTR_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (cursor_q == count_q) begin
					rd_addr = 1'(count_q != '0) ? PTR_W'(count_q - 1'b1) : '0;
				end
			end
			S_WALK: begin
				if (rd_data.ptime <= sample_q) begin
					rd_addr = next_cursor[PTR_W-1:0];
				end else begin
					rd_addr = PTR_W'(cursor_q - 1'b1);
				end
			end
			default: rd_addr = cursor_q[PTR_W-1:0];
		endcase
	end

	always_comb begin
		div_req.start = (state_q == S_PREV) && (sample_q >= rd_data.ptime)
			&& (t1_q != rd_data.ptime);
		div_req.num   = sample_q - rd_data.ptime;
		div_req.den   = t1_q - rd_data.ptime;
	end

	// The floor of (v1 - v0) * frac / 256 is an arithmetic shift; the result
	// always lies between the two levels, so no clamping is needed.
	assign diff = $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});
	assign lvl  = $signed({{(PROD_W-LEVEL_W-8){1'b0}}, v0_q, 8'h00}) + (prod_q >>> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			last_time_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && (!res_valid_q || !res_stall)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sample_q         <= cmd.sample_time;
						pend_q.level_out <= '0;
						case (cmd.operation)
							OP_CLEAR: begin
								count_q       <= '0;
								cursor_q      <= '0;
								last_time_q   <= '0;
								pend_q.status <= ST_OK;
								state_q       <= S_DONE;
							end
							OP_APPEND: begin
								state_q <= S_DONE;
								if (full) begin
									pend_q.status <= ST_FULL;
								end else begin
									pend_q.status <= ST_OK;
									count_q       <= count_q + 1'b1;
									last_time_q   <= new_time;
								end
							end
							OP_EVAL: begin
								if (count_q == '0) begin
									pend_q.status <= ST_EMPTY;
									state_q       <= S_DONE;
								end else if (cursor_q == count_q) begin
									pend_q.status <= ST_OK;
									state_q       <= S_LAST;
								end else begin
									pend_q.status <= ST_OK;
									state_q       <= S_WALK;
								end
							end
							default: begin
								pend_q.status <= ST_OK;
								state_q       <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (rd_data.ptime <= sample_q) begin
						cursor_q <= next_cursor;
						if (next_cursor == count_q) begin
							pend_q.level_out <= {rd_data.plevel, 8'h00};
							state_q          <= S_DONE;
						end
					end else if (cursor_q == '0) begin
						pend_q.level_out <= {rd_data.plevel, 8'h00};
						state_q          <= S_DONE;
					end else begin
						t1_q    <= rd_data.ptime;
						v1_q    <= rd_data.plevel;
						state_q <= S_PREV;
					end
				end
				S_PREV: begin
					v0_q   <= rd_data.plevel;
					frac_q <= '0;
					if (sample_q < rd_data.ptime) begin
						pend_q.status <= ST_CLAMP;
						state_q       <= S_MUL;
					end else if (t1_q == rd_data.ptime) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_LAST: begin
					pend_q.level_out <= {rd_data.plevel, 8'h00};
					state_q          <= S_DONE;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						frac_q  <= div_rsp.quot;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(diff) * PROD_W'($signed({1'b0, frac_q}));
					state_q <= S_FIN;
				end
				S_FIN: begin
					pend_q.level_out <= lvl[OUT_W-1:0];
					state_q          <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q   <= pend_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	bei_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bei_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
